[rtl/core/chtab_pkg.sv]
// Shared types and constants for the chained hash table.
`timescale 1ns / 1ps
package chtab_pkg;

    localparam int BUCKETS_DEF    = 256;
    localparam int POOL_NODES_DEF = 256;

    localparam logic [8:0] TABLE_SIZE_RESET = 9'd179;

    localparam int ID_W  = 31;
    localparam int REC_W = 32;
    localparam int TS_W  = 9;

    // Modulo unit: key bits handled per cycle and number of cycles.
    localparam int MOD_BITS   = 4;
    localparam int MOD_CYCLES = 8;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic ADDR_TABLE_SIZE = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_HRD,
        ST_HCHK,
        ST_PRD,
        ST_PCHK,
        ST_DONE
    } t_state;

endpackage

[rtl/core/chtab_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module chtab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/chained_hash_table.sv]
// Top level of the chained hash table: control, modulo unit and the two record memories.
`timescale 1ns / 1ps
// A request (start while busy is low) runs the bucket modulo, which handles four
// key bits a cycle, then reads and checks the head slot, then reads and checks
// every chained node visited, and ends in a state in which the result is shown
// with o_valid. Results cannot be held off: o_valid is high for exactly one cycle.
// Bucket heads and pool nodes live in two synchronous RAMs; their valid and in-use
// marks are flip-flops cleared at reset.
module chained_hash_table #(
    parameter int BUCKETS    = chtab_pkg::BUCKETS_DEF,
    parameter int POOL_NODES = chtab_pkg::POOL_NODES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_mode,
    input  logic [chtab_pkg::ID_W-1:0]   i_key_id,
    input  logic [chtab_pkg::REC_W-1:0]  i_record_word,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [chtab_pkg::REC_W-1:0]  o_found_record,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import chtab_pkg::*;

    localparam int HAW = $clog2(BUCKETS);
    localparam int PAW = $clog2(POOL_NODES);
    localparam int LW  = $clog2(POOL_NODES + 1);
    localparam logic [LW-1:0] END_LINK = LW'(POOL_NODES);
    localparam int NODE_W = ID_W + REC_W + LW;
    localparam int DATA_W = ID_W + REC_W;

    t_state r_state, n_state;

    logic [TS_W-1:0] r_tsize;
    logic [1:0]      r_mode;
    logic [ID_W-1:0] r_key;
    logic [REC_W-1:0] r_word;

    logic [TS_W-1:0] r_rem, n_rem;
    logic [31:0]     r_qsh;
    logic [2:0]      r_cnt;
    logic [HAW-1:0]  r_bucket;

    logic [BUCKETS-1:0]    r_hvalid;
    logic [POOL_NODES-1:0] r_used;
    logic [PAW-1:0]        r_free_idx, n_free_idx;
    logic                  r_free_ok;
    logic [PAW-1:0]        r_node, n_node;

    logic [LW-1:0]     r_cur, n_cur;
    logic [LW-1:0]     r_prev, n_prev;
    logic [DATA_W-1:0] r_prev_data, n_prev_data;
    logic [DATA_W-1:0] r_hdata, n_hdata;
    logic              r_pull, n_pull;
    logic [1:0]        r_status, n_status;
    logic [REC_W-1:0]  r_rec, n_rec;

    logic              h_we, p_we;
    logic [NODE_W-1:0] h_wdata, p_wdata, h_rdata, p_rdata;
    logic [PAW-1:0]    p_waddr;
    logic              hv_set, hv_clr, pu_set, pu_clr;
    logic [PAW-1:0]    pu_idx;

    logic [ID_W-1:0]  h_id, p_id;
    logic [REC_W-1:0] h_rec, p_rec;
    logic [LW-1:0]    h_link, p_link;
    logic             h_valid, h_hit, p_hit, h_link_ok, p_link_ok;
    logic             hchk_walk, pchk_walk;
    logic [TS_W-1:0]  n_eff;
    logic             accept, cfg_wr;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TABLE_SIZE) ? {{(32 - TS_W){1'b0}}, r_tsize} : 32'd0;

    assign {h_id, h_rec, h_link} = h_rdata;
    assign {p_id, p_rec, p_link} = p_rdata;
    assign h_valid   = r_hvalid[r_bucket];
    assign h_hit     = (h_id == r_key);
    assign p_hit     = (p_id == r_key);
    assign h_link_ok = (h_link < END_LINK);
    assign p_link_ok = (p_link < END_LINK);

    chtab_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_head_ram (
        .i_clk  (i_clk),
        .i_we   (h_we),
        .i_waddr(r_bucket),
        .i_wdata(h_wdata),
        .i_raddr(r_bucket),
        .o_rdata(h_rdata)
    );

    chtab_ram #(.WIDTH(NODE_W), .DEPTH(POOL_NODES)) u_pool_ram (
        .i_clk  (i_clk),
        .i_we   (p_we),
        .i_waddr(p_waddr),
        .i_wdata(p_wdata),
        .i_raddr(r_cur[PAW-1:0]),
        .o_rdata(p_rdata)
    );

    // Effective modulus: zero acts as one, anything above the bucket count saturates.
    always_comb begin
        n_eff = r_tsize;
        if (r_tsize == '0) begin
            n_eff = TS_W'(1);
        end else if (32'(r_tsize) > 32'(BUCKETS)) begin
            n_eff = TS_W'(BUCKETS);
        end
    end

    // Restoring remainder, four key bits per cycle, most significant first.
    always_comb begin
        logic [TS_W:0] t;
        n_rem = r_rem;
        for (int i = 0; i < MOD_BITS; i++) begin
            t = {n_rem, r_qsh[31 - i]};
            if (t >= {1'b0, n_eff}) begin
                t = t - {1'b0, n_eff};
            end
            n_rem = t[TS_W-1:0];
        end
    end

    // Lowest free pool node, isolated as the lowest set bit of the free mask.
    always_comb begin
        logic [POOL_NODES-1:0] free_vec, low;
        free_vec   = ~r_used;
        low        = free_vec & (~free_vec + 1'b1);
        n_free_idx = '0;
        for (int i = 0; i < POOL_NODES; i++) begin
            if (low[i]) begin
                n_free_idx = n_free_idx | PAW'(i);
            end
        end
    end

    assign hchk_walk = h_valid && (
        (r_mode == MODE_INSERT && r_free_ok && h_link_ok) ||
        (r_mode == MODE_SEARCH && !h_hit && h_link_ok) ||
        (r_mode == MODE_REMOVE && h_link_ok));
    assign pchk_walk = !r_pull && p_link_ok && (r_mode == MODE_INSERT || !p_hit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_MOD;
            ST_MOD:  if (r_cnt == 3'(MOD_CYCLES - 1)) n_state = ST_HRD;
            ST_HRD:  n_state = ST_HCHK;
            ST_HCHK: n_state = hchk_walk ? ST_PRD : ST_DONE;
            ST_PRD:  n_state = ST_PCHK;
            ST_PCHK: n_state = pchk_walk ? ST_PRD : ST_DONE;
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        h_we        = 1'b0;
        h_wdata     = {r_key, r_word, END_LINK};
        p_we        = 1'b0;
        p_waddr     = r_free_idx;
        p_wdata     = {r_key, r_word, END_LINK};
        hv_set      = 1'b0;
        hv_clr      = 1'b0;
        pu_set      = 1'b0;
        pu_clr      = 1'b0;
        pu_idx      = r_cur[PAW-1:0];
        n_cur       = r_cur;
        n_prev      = r_prev;
        n_prev_data = r_prev_data;
        n_hdata     = r_hdata;
        n_pull      = r_pull;
        n_node      = r_node;
        n_status    = r_status;
        n_rec       = r_rec;
        unique case (r_state)
            ST_HCHK: begin
                n_status = STATUS_NOTFOUND;
                n_rec    = '0;
                n_pull   = 1'b0;
                n_hdata  = {h_id, h_rec};
                n_prev   = END_LINK;
                n_cur    = h_link;
                n_node   = r_free_idx;
                if (r_mode == MODE_INSERT) begin
                    if (!h_valid) begin
                        h_we     = 1'b1;
                        hv_set   = 1'b1;
                        n_status = STATUS_OK;
                    end else if (!r_free_ok) begin
                        n_status = STATUS_FULL;
                    end else begin
                        p_we     = 1'b1;
                        pu_set   = 1'b1;
                        pu_idx   = r_free_idx;
                        n_status = STATUS_OK;
                        if (!h_link_ok) begin
                            h_we    = 1'b1;
                            h_wdata = {h_id, h_rec, LW'(r_free_idx)};
                        end
                    end
                end else if (r_mode == MODE_SEARCH) begin
                    if (h_valid && h_hit) begin
                        n_status = STATUS_OK;
                        n_rec    = h_rec;
                    end
                end else if (r_mode == MODE_REMOVE) begin
                    if (h_valid && h_hit) begin
                        if (h_link_ok) begin
                            // The first chained node is pulled into the head slot.
                            n_pull = 1'b1;
                        end else begin
                            hv_clr   = 1'b1;
                            n_status = STATUS_OK;
                        end
                    end
                end
            end
            ST_PCHK: begin
                if (r_pull) begin
                    h_we     = 1'b1;
                    h_wdata  = p_rdata;
                    pu_clr   = 1'b1;
                    n_status = STATUS_OK;
                end else if (r_mode == MODE_INSERT) begin
                    if (p_link_ok) begin
                        n_cur = p_link;
                    end else begin
                        p_we    = 1'b1;
                        p_waddr = r_cur[PAW-1:0];
                        p_wdata = {p_id, p_rec, LW'(r_node)};
                    end
                end else if (r_mode == MODE_SEARCH) begin
                    if (p_hit) begin
                        n_status = STATUS_OK;
                        n_rec    = p_rec;
                    end else begin
                        n_cur = p_link;
                    end
                end else begin
                    if (p_hit) begin
                        if (r_prev == END_LINK) begin
                            h_we    = 1'b1;
                            h_wdata = {r_hdata, p_link};
                        end else begin
                            p_we    = 1'b1;
                            p_waddr = r_prev[PAW-1:0];
                            p_wdata = {r_prev_data, p_link};
                        end
                        pu_clr   = 1'b1;
                        n_status = STATUS_OK;
                    end else begin
                        n_prev      = r_cur;
                        n_prev_data = {p_id, p_rec};
                        n_cur       = p_link;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_tsize   <= TABLE_SIZE_RESET;
            r_hvalid  <= '0;
            r_used    <= '0;
            r_cnt     <= '0;
            r_free_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free_ok <= ~&r_used;
            if (cfg_wr && paddr == ADDR_TABLE_SIZE) begin
                r_tsize <= pwdata[TS_W-1:0];
            end
            if (r_state == ST_MOD) begin
                r_cnt <= r_cnt + 3'd1;
            end else begin
                r_cnt <= '0;
            end
            if (hv_set) r_hvalid[r_bucket] <= 1'b1;
            if (hv_clr) r_hvalid[r_bucket] <= 1'b0;
            if (pu_set) r_used[pu_idx] <= 1'b1;
            if (pu_clr) r_used[pu_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_free_idx  <= n_free_idx;
        r_cur       <= n_cur;
        r_prev      <= n_prev;
        r_prev_data <= n_prev_data;
        r_hdata     <= n_hdata;
        r_pull      <= n_pull;
        r_node      <= n_node;
        r_status    <= n_status;
        r_rec       <= n_rec;
        if (accept) begin
            r_mode <= i_mode;
            r_key  <= i_key_id;
            r_word <= i_record_word;
            r_rem  <= '0;
            r_qsh  <= {1'b0, i_key_id};
        end else if (r_state == ST_MOD) begin
            r_rem <= n_rem;
            r_qsh <= {r_qsh[31-MOD_BITS:0], {MOD_BITS{1'b0}}};
            if (r_cnt == 3'(MOD_CYCLES - 1)) begin
                r_bucket <= HAW'(n_rem);
            end
        end
    end

    assign o_valid        = (r_state == ST_DONE);
    assign o_status       = r_status;
    assign o_found_record = r_rec;
endmodule
